// File: rtl/core/drvs_pkg.sv
package drvs_pkg;

   localparam int NUM_OUT_PORTS           = 16;
   localparam int NUM_VCS                 = 8;
   localparam int MAX_PORTS_PER_INTERFACE = 4;

   localparam int PORT_W      = $clog2(NUM_OUT_PORTS);
   localparam int VC_W        = $clog2(NUM_VCS);
   localparam int ADDR_W      = PORT_W + VC_W;
   localparam int TABLE_DEPTH = NUM_OUT_PORTS * NUM_VCS;
   localparam int VAL_W       = 16;
   localparam int TIE_W       = 6;

   localparam int DEST_W      = 4;
   localparam int PPI_W       = 3;
   localparam int TERM_W      = 5;
   localparam int FVC_W       = 3;
   localparam int VCNT_W      = 4;
   localparam int SPAN_W      = DEST_W + PPI_W;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PPI      = 3'd0,
      CSR_TERM     = 3'd1,
      CSR_FIRST_VC = 3'd2,
      CSR_VC_COUNT = 3'd3,
      CSR_ADAPTIVE = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_ROUTE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR,
      ST_PLAIN,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT_RD,
      ST_EMIT_CHK
   } state_type;

endpackage

// File: rtl/core/drvs_if.sv
interface drvs_req_if import drvs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [DEST_W-1:0]  dest_terminal;
   logic [PORT_W-1:0]  entry_port;
   logic [VC_W-1:0]    entry_vc;
   logic [VAL_W-1:0]   congestion_value;

   modport source (output valid, opcode, dest_terminal, entry_port, entry_vc,
                   congestion_value, input ready);
   modport sink   (input valid, opcode, dest_terminal, entry_port, entry_vc,
                   congestion_value, output ready);
endinterface

interface drvs_rsp_if import drvs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] out_port;
   logic [VC_W-1:0]   out_vc;
   logic              last;
   logic              route_error;

   modport source (output valid, out_port, out_vc, last, route_error, input ready);
   modport sink   (input valid, out_port, out_vc, last, route_error, output ready);
endinterface

interface drvs_csr_if import drvs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/direct_route_vc_select.sv
// Route computation with adaptive virtual channel selection for one router input.
// Requests arrive on req_chan. A write request (opcode 0) stores one congestion
// entry and produces no response. A route request (opcode 1) produces one or
// more responses on rsp_chan, the final one flagged by last.
// For a route request covering N port and VC pairs:
//   plain mode: one response per cycle while the receiver does not stall;
//   adaptive mode: a minimum pass and an emit pass over the congestion store,
//   each reading a pair in one state and checking it in the next, through the
//   store's single registered read port (N is at most 32).
// A request whose port run leaves the terminal ports gives one error response,
// flagged by last. req_chan is ready only between route requests, so one
// route request is worked on at a time. Responses sit in an output register;
// when the receiver stalls, the sequencer waits with the next candidate.
// Reset clears the configuration to its defaults and marks every congestion
// entry as zero through a valid bit per entry, so no clearing pass is needed.
// csr_chan is always ready and must only be written while the block is idle.
module direct_route_vc_select
   import drvs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   drvs_req_if.sink     req_chan,
   drvs_rsp_if.source   rsp_chan,
   drvs_csr_if.sink     csr_chan
);

   logic [PPI_W-1:0]     ppi_ff;
   logic [TERM_W-1:0]    term_ff;
   logic [FVC_W-1:0]     first_vc_ff;
   logic [VCNT_W-1:0]    vc_count_ff;
   logic                 adaptive_ff;

   state_type            state_ff, state_in;
   logic [PORT_W-1:0]    port_ff, port_in;
   logic [VC_W-1:0]      vc_ff, vc_in;
   logic [PORT_W-1:0]    start_port_ff, start_port_in;
   logic [PORT_W-1:0]    last_port_ff, last_port_in;
   logic [VC_W-1:0]      vlo_ff, vlo_in;
   logic [VC_W-1:0]      vhi_m1_ff, vhi_m1_in;
   logic [VAL_W-1:0]     min_ff, min_in;
   logic [TIE_W-1:0]     ties_ff, ties_in;
   logic                 first_ff, first_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]    rsp_port_ff, rsp_port_in;
   logic [VC_W-1:0]      rsp_vc_ff, rsp_vc_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic [VAL_W-1:0]     cong_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cong_vld_ff;
   logic [VAL_W-1:0]     rd_data_ff;
   logic                 rd_zero_ff;
   logic                 rd_en;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;

   logic                 req_acc;
   logic                 route_acc;
   logic                 out_free;
   logic                 at_vc_end;
   logic                 at_end;
   logic [PORT_W-1:0]    adv_port;
   logic [VC_W-1:0]      adv_vc;
   logic [VAL_W-1:0]     rd_value;
   logic                 is_tie;

   logic [PPI_W-1:0]     ppi_eff;
   logic [VCNT_W-1:0]    vcnt_eff;
   logic [VC_W-1:0]      vlo_eff;
   logic [VCNT_W:0]      vhi_sum;
   logic [VCNT_W:0]      vhi_clip;
   logic [SPAN_W-1:0]    base;
   logic [SPAN_W-1:0]    span_end;
   logic                 route_err;

   // Configuration registers.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppi_ff      <= PPI_W'(1);
         term_ff     <= TERM_W'(16);
         first_vc_ff <= '0;
         vc_count_ff <= VCNT_W'(1);
         adaptive_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PPI:      ppi_ff      <= csr_chan.data[PPI_W-1:0];
            CSR_TERM:     term_ff     <= csr_chan.data[TERM_W-1:0];
            CSR_FIRST_VC: first_vc_ff <= csr_chan.data[FVC_W-1:0];
            CSR_VC_COUNT: vc_count_ff <= csr_chan.data[VCNT_W-1:0];
            CSR_ADAPTIVE: adaptive_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // Request decode and route window.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc   = req_chan.valid && req_chan.ready;
   assign route_acc = req_acc && (req_chan.opcode == OP_ROUTE);

   always_comb begin
      if (ppi_ff == '0) begin
         ppi_eff = PPI_W'(1);
      end else if (32'(ppi_ff) > MAX_PORTS_PER_INTERFACE) begin
         ppi_eff = PPI_W'(MAX_PORTS_PER_INTERFACE);
      end else begin
         ppi_eff = ppi_ff;
      end
      vcnt_eff = (vc_count_ff == '0) ? VCNT_W'(1) : vc_count_ff;
      vlo_eff  = (32'(first_vc_ff) >= NUM_VCS) ? VC_W'(NUM_VCS - 1)
                                               : VC_W'(first_vc_ff);
      vhi_sum  = (VCNT_W+1)'(vlo_eff) + (VCNT_W+1)'(vcnt_eff);
      vhi_clip = (32'(vhi_sum) > NUM_VCS) ? (VCNT_W+1)'(NUM_VCS) : vhi_sum;
      base     = SPAN_W'(req_chan.dest_terminal) * SPAN_W'(ppi_eff);
      span_end = base + SPAN_W'(ppi_eff);
      route_err = (span_end > SPAN_W'(term_ff)) || (32'(span_end) > NUM_OUT_PORTS);
   end

   // Scan position.
   assign at_vc_end = (vc_ff == vhi_m1_ff);
   assign at_end    = at_vc_end && (port_ff == last_port_ff);
   assign adv_vc    = at_vc_end ? vlo_ff : vc_ff + VC_W'(1);
   assign adv_port  = at_vc_end ? port_ff + PORT_W'(1) : port_ff;
   assign rd_value  = rd_zero_ff ? '0 : rd_data_ff;
   assign is_tie    = (rd_value == min_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (route_acc) begin
               if (route_err) begin
                  state_in = ST_ERROR;
               end else if (adaptive_ff) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_PLAIN;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_PLAIN: begin
            if (out_free && at_end) state_in = ST_IDLE;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = at_end ? ST_EMIT_RD : ST_SCAN_RD;
         ST_EMIT_RD: state_in = ST_EMIT_CHK;
         ST_EMIT_CHK: begin
            if (is_tie) begin
               if (out_free) begin
                  state_in = (ties_ff == TIE_W'(1)) ? ST_IDLE : ST_EMIT_RD;
               end
            end else begin
               state_in = at_end ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      port_in       = port_ff;
      vc_in         = vc_ff;
      start_port_in = start_port_ff;
      last_port_in  = last_port_ff;
      vlo_in        = vlo_ff;
      vhi_m1_in     = vhi_m1_ff;
      min_in        = min_ff;
      ties_in       = ties_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_port_in   = rsp_port_ff;
      rsp_vc_in     = rsp_vc_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      rd_en         = 1'b0;
      wr_en         = req_acc && (req_chan.opcode == OP_WRITE)
                      && (32'(req_chan.entry_port) < NUM_OUT_PORTS)
                      && (32'(req_chan.entry_vc) < NUM_VCS);
      wr_addr       = {req_chan.entry_port, req_chan.entry_vc};
      case (state_ff)
         ST_IDLE: begin
            if (route_acc) begin
               port_in       = base[PORT_W-1:0];
               start_port_in = base[PORT_W-1:0];
               last_port_in  = PORT_W'(span_end - SPAN_W'(1));
               vc_in         = vlo_eff;
               vlo_in        = vlo_eff;
               vhi_m1_in     = VC_W'(vhi_clip - (VCNT_W+1)'(1));
               first_in      = 1'b1;
               ties_in       = '0;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = '0;
               rsp_vc_in    = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
            end
         end
         ST_PLAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = port_ff;
               rsp_vc_in    = vc_ff;
               rsp_last_in  = at_end;
               rsp_err_in   = 1'b0;
               port_in      = adv_port;
               vc_in        = adv_vc;
            end
         end
         ST_SCAN_RD, ST_EMIT_RD: rd_en = 1'b1;
         ST_SCAN_CHK: begin
            first_in = 1'b0;
            if (first_ff || (rd_value < min_ff)) begin
               min_in  = rd_value;
               ties_in = TIE_W'(1);
            end else if (is_tie) begin
               ties_in = ties_ff + TIE_W'(1);
            end
            if (at_end) begin
               port_in = start_port_ff;
               vc_in   = vlo_ff;
            end else begin
               port_in = adv_port;
               vc_in   = adv_vc;
            end
         end
         ST_EMIT_CHK: begin
            if (is_tie) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_port_in  = port_ff;
                  rsp_vc_in    = vc_ff;
                  rsp_last_in  = (ties_ff == TIE_W'(1));
                  rsp_err_in   = 1'b0;
                  ties_in      = ties_ff - TIE_W'(1);
                  port_in      = adv_port;
                  vc_in        = adv_vc;
               end
            end else begin
               port_in = adv_port;
               vc_in   = adv_vc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         ties_ff      <= '0;
         min_ff       <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         ties_ff      <= ties_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff       <= port_in;
      vc_ff         <= vc_in;
      start_port_ff <= start_port_in;
      last_port_ff  <= last_port_in;
      vlo_ff        <= vlo_in;
      vhi_m1_ff     <= vhi_m1_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_vc_ff     <= rsp_vc_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   // Congestion store: entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cong_mem[wr_addr] <= req_chan.congestion_value;
      end
      if (rd_en) begin
         rd_data_ff <= cong_mem[{port_ff, vc_ff}];
         rd_zero_ff <= !cong_vld_ff[{port_ff, vc_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cong_vld_ff <= '0;
      end else if (wr_en) begin
         cong_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_port    = rsp_port_ff;
   assign rsp_chan.out_vc      = rsp_vc_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.route_error = rsp_err_ff;

   a_emit_has_ties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_CHK) |-> (ties_ff != '0))
      else $error("emit pass running with no ties left");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_last_ff)
      else $error("error response without last");

   a_route_blocks: assert property (@(posedge clock) disable iff (reset)
      route_acc |=> !req_chan.ready)
      else $error("request taken straight after a route request");

   a_min_falls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CHK && !first_ff) |=> (min_ff <= $past(min_ff)))
      else $error("running minimum rose during a scan");

endmodule

// File: tb/sv/tb.sv
module tb;
   import drvs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TOTAL_REQUESTS = 350;
   localparam int unsigned QUIET_TAIL     = 60;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned STALL_LIMIT    = 4000;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [VC_W-1:0]   vc;
      logic              last;
      logic              route_error;
   } vc_choice_type;

   class route_book_type;
      logic [VAL_W-1:0]  congestion [TABLE_DEPTH];
      logic [PPI_W-1:0]  ppi_reg;
      logic [TERM_W-1:0] term_reg;
      logic [FVC_W-1:0]  first_vc_reg;
      logic [VCNT_W-1:0] vc_count_reg;
      logic              adaptive_reg;
      vc_choice_type     awaited [$];
      int unsigned       failures;

      function new();
         foreach (congestion[i]) congestion[i] = '0;
         ppi_reg      = 1;
         term_reg     = 16;
         first_vc_reg = 0;
         vc_count_reg = 1;
         adaptive_reg = 0;
         failures     = 0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void queue_choice(vc_choice_type item);
         awaited.insert(awaited.size(), item);
      endfunction

      function int unsigned span_ports();
         if (ppi_reg == 0) return 1;
         if (ppi_reg > MAX_PORTS_PER_INTERFACE) return MAX_PORTS_PER_INTERFACE;
         return ppi_reg;
      endfunction

      function int unsigned vc_high();
         int unsigned h;
         h = first_vc_reg + ((vc_count_reg == 0) ? 1 : vc_count_reg);
         return (h > NUM_VCS) ? NUM_VCS : h;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PPI: begin
               ppi_reg = data[PPI_W-1:0];
            end
            CSR_TERM: begin
               term_reg = data[TERM_W-1:0];
            end
            CSR_FIRST_VC: begin
               first_vc_reg = data[FVC_W-1:0];
            end
            CSR_VC_COUNT: begin
               vc_count_reg = data[VCNT_W-1:0];
            end
            CSR_ADAPTIVE: begin
               adaptive_reg = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_request(opcode_type op, logic [DEST_W-1:0] dest,
                                 logic [PORT_W-1:0] eport, logic [VC_W-1:0] evc,
                                 logic [VAL_W-1:0] value);
         int unsigned ppi, vhi, base, least, ties, seen, p, v, idx;
         if (op == OP_WRITE) begin
            congestion[eport * NUM_VCS + evc] = value;
            return;
         end
         ppi  = span_ports();
         vhi  = vc_high();
         base = dest * ppi;
         if (base + ppi > term_reg || base + ppi > NUM_OUT_PORTS) begin
            queue_choice('{port: '0, vc: '0, last: 1'b1, route_error: 1'b1});
            return;
         end
         // The first pair scanned always sets the minimum, even at all ones.
         least = 32'hFFFF_FFFF;
         ties  = 0;
         for (p = base; p < base + ppi; p++) begin
            for (v = first_vc_reg; v < vhi; v++) begin
               idx = p * NUM_VCS + v;
               if (!adaptive_reg) begin
                  ties++;
               end else if (congestion[idx] < least) begin
                  least = congestion[idx];
                  ties  = 1;
               end else if (congestion[idx] == least) begin
                  ties++;
               end
            end
         end
         seen = 0;
         for (p = base; p < base + ppi; p++) begin
            for (v = first_vc_reg; v < vhi; v++) begin
               idx = p * NUM_VCS + v;
               if (!adaptive_reg || congestion[idx] == least) begin
                  seen++;
                  queue_choice('{port: p[PORT_W-1:0], vc: v[VC_W-1:0],
                                 last: (seen == ties), route_error: 1'b0});
               end
            end
         end
      endfunction

      function void check_choice(vc_choice_type got);
         vc_choice_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none,",
                     $time);
            $display("%0t: got port %0d vc %0d last %0b error %0b",
                     $time, got.port, got.vc, got.last, got.route_error);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.port != want.port) begin
            $display("%0t: out_port expected %0d, got %0d", $time, want.port, got.port);
            failures++;
         end
         if (got.vc != want.vc) begin
            $display("%0t: out_vc expected %0d, got %0d", $time, want.vc, got.vc);
            failures++;
         end
         if (got.last != want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
            failures++;
         end
         if (got.route_error != want.route_error) begin
            $display("%0t: route_error expected %0b, got %0b", $time, want.route_error,
                     got.route_error);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   drvs_req_if req_chan ();
   drvs_rsp_if rsp_chan ();
   drvs_csr_if csr_chan ();

   route_book_type   book;
   int unsigned      requests_sent;
   bit               quiet_tail;

   direct_route_vc_select dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            book.write_register(csr_chan.index, csr_chan.data);
         end
         if (req_chan.valid && req_chan.ready) begin
            book.note_request(opcode_type'(req_chan.opcode), req_chan.dest_terminal,
                              req_chan.entry_port, req_chan.entry_vc,
                              req_chan.congestion_value);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            book.check_choice('{rsp_chan.out_port, rsp_chan.out_vc, rsp_chan.last,
                                rsp_chan.route_error});
         end
      end
   end

   initial begin
      bit stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = !quiet_tail && ($urandom_range(0, 2) == 0);
         rsp_chan.ready <= !stall;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   end

   initial begin
      int unsigned stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("[direct_route_vc_select] ERROR");
      $finish;
   end

   function automatic logic [VAL_W-1:0] congestion_sample();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return VAL_W'($urandom_range(0, 3));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic send_request(opcode_type op, logic [DEST_W-1:0] dest,
                               logic [PORT_W-1:0] eport, logic [VC_W-1:0] evc,
                               logic [VAL_W-1:0] value);
      req_chan.valid            <= 1'b1;
      req_chan.opcode           <= op;
      req_chan.dest_terminal    <= dest;
      req_chan.entry_port       <= eport;
      req_chan.entry_vc         <= evc;
      req_chan.congestion_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic route_to(logic [DEST_W-1:0] dest);
      send_request(OP_ROUTE, dest, PORT_W'($urandom), VC_W'($urandom), VAL_W'($urandom));
   endtask

   task automatic store_congestion(logic [PORT_W-1:0] eport, logic [VC_W-1:0] evc,
                                   logic [VAL_W-1:0] value);
      send_request(OP_WRITE, DEST_W'($urandom), eport, evc, value);
   endtask

   task automatic maybe_pause(int unsigned odds);
      if (!quiet_tail && $urandom_range(0, 3) < odds) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // A write request gives no response, so a settling wait follows the last response to let it retire.
   task automatic wait_for_routes();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] ppi, logic [CSR_DATA_W-1:0] term,
                            logic [CSR_DATA_W-1:0] first_vc, logic [CSR_DATA_W-1:0] vc_count,
                            logic [CSR_DATA_W-1:0] mode);
      wait_for_routes();
      write_csr(CSR_PPI, ppi);
      write_csr(CSR_TERM, term);
      write_csr(CSR_FIRST_VC, first_vc);
      write_csr(CSR_VC_COUNT, vc_count);
      write_csr(CSR_ADAPTIVE, mode);
      write_csr(CSR_IDX_W'($urandom_range(CSR_ADAPTIVE + 1, 7)), CSR_DATA_W'($urandom));
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned       ppi, vhi, reach, gap_odds, phase_end;
      logic [DEST_W-1:0] dest;
      logic [PORT_W-1:0] port;
      logic [VC_W-1:0]   vc;

      book          = new();
      requests_sent = 0;
      quiet_tail    = 1'b0;
      reset         = 1'b1;

      req_chan.valid            = 1'b0;
      req_chan.opcode           = OP_WRITE;
      req_chan.dest_terminal    = '0;
      req_chan.entry_port       = '0;
      req_chan.entry_vc         = '0;
      req_chan.congestion_value = '0;
      csr_chan.valid            = 1'b0;
      csr_chan.index            = CSR_PPI;
      csr_chan.data             = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration first, then the window and mode extremes.
      route_to(4'd0);
      route_to(4'd15);
      store_congestion(4'd15, 3'd7, 16'hFFFF);
      store_congestion(4'd0, 3'd0, 16'h0000);

      configure(5'd4, 5'd16, 5'd0, 5'd8, 5'd1);
      store_congestion(4'd12, 3'd0, 16'h0001);
      route_to(4'd3);
      route_to(4'd4);

      configure(5'd1, 5'd16, 5'd7, 5'd1, 5'd1);
      store_congestion(4'd2, 3'd7, 16'hFFFF);
      route_to(4'd2);

      configure(5'd0, 5'd0, 5'd7, 5'd0, 5'd0);
      route_to(4'd0);

      configure(5'd7, 5'd31, 5'd5, 5'd15, 5'd0);
      route_to(4'd3);
      route_to(4'd4);
      route_to(4'd15);

      configure(5'd7, 5'd31, 5'd5, 5'd15, 5'd1);
      store_congestion(4'd12, 3'd5, 16'h0002);
      store_congestion(4'd14, 3'd6, 16'h8000);
      route_to(4'd3);

      configure(5'd1, 5'd1, 5'd0, 5'd8, 5'd0);
      route_to(4'd0);
      route_to(4'd1);

      while (requests_sent < TOTAL_REQUESTS) begin
         quiet_tail = (requests_sent + QUIET_TAIL >= TOTAL_REQUESTS);
         configure(CSR_DATA_W'($urandom),
                   ($urandom_range(0, 3) != 0) ? 5'd16 : CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         gap_odds  = $urandom_range(0, 3);
         phase_end = requests_sent + $urandom_range(20, 45);
         while (requests_sent < phase_end && requests_sent < TOTAL_REQUESTS) begin
            ppi   = book.span_ports();
            vhi   = book.vc_high();
            reach = (book.term_reg < NUM_OUT_PORTS) ? book.term_reg : NUM_OUT_PORTS;
            if (reach >= ppi && $urandom_range(0, 7) != 0) begin
               dest = DEST_W'($urandom_range(0, reach / ppi - 1));
            end else begin
               dest = DEST_W'($urandom);
            end
            if (book.adaptive_reg && $urandom_range(0, 3) != 0) begin
               // Load a few entries in the run of the destination, then route to it.
               repeat ($urandom_range(1, 6)) begin
                  port = PORT_W'(dest * ppi + $urandom_range(0, ppi - 1));
                  if ($urandom_range(0, 3) != 0) begin
                     vc = VC_W'(book.first_vc_reg + $urandom_range(0, vhi - book.first_vc_reg - 1));
                  end else begin
                     vc = VC_W'($urandom);
                  end
                  maybe_pause(gap_odds);
                  store_congestion(port, vc, congestion_sample());
               end
               maybe_pause(gap_odds);
               route_to(dest);
            end else begin
               maybe_pause(gap_odds);
               if ($urandom_range(0, 9) < 7) begin
                  route_to(dest);
               end else begin
                  store_congestion(PORT_W'($urandom), VC_W'($urandom), congestion_sample());
               end
            end
         end
      end

      wait_for_routes();
      if (book.failures == 0) begin
         $display("[direct_route_vc_select] OK");
      end else begin
         $display("[direct_route_vc_select] ERROR");
      end
      $finish;
   end

endmodule

// File: direct_route_vc_select.f
rtl/core/drvs_pkg.sv
rtl/core/drvs_if.sv
rtl/core/direct_route_vc_select.sv
tb/sv/tb.sv
